// ===== rtl/chat_request_frame_validator_defines.svh =====
// ----------------------------------------------------------------------------
// chat request frame validator assertion macros
// shared assertion forms, clocked on clk with synchronous active-low reset
// ----------------------------------------------------------------------------
`ifndef CHAT_REQUEST_FRAME_VALIDATOR_DEFINES_SVH
`define CHAT_REQUEST_FRAME_VALIDATOR_DEFINES_SVH

// checked only while out of reset
`define CRFV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define CRFV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/crfv_pkg.sv =====
// ----------------------------------------------------------------------------
// crfv_pkg
// types and constants shared by the request frame validator modules
// ----------------------------------------------------------------------------
`default_nettype none

package crfv_pkg;

  localparam int unsigned POS_W = 17;
  localparam int unsigned LEN_W = 16;

  localparam logic [POS_W-1:0] POS_MAX   = '1;
  localparam logic [POS_W-1:0] HDR_BYTES = POS_W'(9);

  // header offsets
  localparam logic [POS_W-1:0] OFS_VERSION = POS_W'(4);
  localparam logic [POS_W-1:0] OFS_CHANNEL = POS_W'(5);
  localparam logic [POS_W-1:0] OFS_SLOT    = POS_W'(6);
  localparam logic [POS_W-1:0] OFS_LEN_HI  = POS_W'(7);
  localparam logic [POS_W-1:0] OFS_LEN_LO  = POS_W'(8);
  localparam logic [POS_W-1:0] MAGIC_BYTES = POS_W'(4);

  localparam logic [7:0] MAGIC [4] = '{8'h50, 8'h43, 8'h48, 8'h54};  // "PCHT"

  localparam logic [7:0] PAYLOAD_MIN = 8'h20;
  localparam logic [7:0] PAYLOAD_DEL = 8'h7f;

  typedef enum logic [1:0] {
    CFG_VERSION     = 2'd0,
    CFG_CHANNEL     = 2'd1,
    CFG_MEMBER_LIM  = 2'd2,
    CFG_MAX_MSG     = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0]       version_value;
    logic [7:0]       party_channel_code;
    logic [7:0]       member_limit;
    logic [LEN_W-1:0] max_msg_len;
  } cfg_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } byte_item_t;

  typedef struct packed {
    logic             accepted;
    logic [7:0]       sender_slot;
    logic [LEN_W-1:0] message_length;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/crfv_in_stage.sv =====
// ----------------------------------------------------------------------------
// crfv_in_stage
// input register holding one byte transaction until the check stage takes it
// ----------------------------------------------------------------------------
`default_nettype none

module crfv_in_stage
  import crfv_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_frame_byte,
  input  wire logic       in_frame_end,
  input  wire logic       advance,
  output logic            item_valid,
  output byte_item_t      item
);

  logic       valid_r, valid_nxt;
  byte_item_t item_r;
  logic       take;

  assign in_stall = valid_r && !advance;
  assign take     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r.frame_byte <= in_frame_byte;
      item_r.frame_end  <= in_frame_end;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

`default_nettype wire

// ===== rtl/crfv_frame_chk.sv =====
// ----------------------------------------------------------------------------
// crfv_frame_chk
// per-byte header and payload checks with the running frame state
// ----------------------------------------------------------------------------
`default_nettype none

module crfv_frame_chk
  import crfv_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       advance,
  input  wire byte_item_t item,
  input  wire cfg_t       cfg,
  output result_t         result
);

  logic [POS_W-1:0] pos_r, pos_nxt, pos_inc;
  logic             ok_r, ok_nxt, ok_byte;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [7:0]       slot_r, slot_nxt;
  logic [7:0]       b;
  logic             size_ok;

  assign b = item.frame_byte;

  always_comb begin
    ok_byte  = ok_r;
    len_nxt  = len_r;
    slot_nxt = slot_r;
    priority if (pos_r < MAGIC_BYTES) begin
      if (b != MAGIC[pos_r[1:0]]) ok_byte = 1'b0;
    end else if (pos_r == OFS_VERSION) begin
      if (b != cfg.version_value) ok_byte = 1'b0;
    end else if (pos_r == OFS_CHANNEL) begin
      if (b != cfg.party_channel_code) ok_byte = 1'b0;
    end else if (pos_r == OFS_SLOT) begin
      slot_nxt = b;
      if (b == 8'd0 || b >= cfg.member_limit) ok_byte = 1'b0;
    end else if (pos_r == OFS_LEN_HI) begin
      len_nxt = {b, 8'd0};
    end else if (pos_r == OFS_LEN_LO) begin
      len_nxt = {len_r[LEN_W-1:8], b};
      if (len_nxt == '0 || len_nxt > cfg.max_msg_len) ok_byte = 1'b0;
    end else begin
      if (b < PAYLOAD_MIN || b == PAYLOAD_DEL) ok_byte = 1'b0;
    end
  end

  // saturating byte count, this is the frame size on the last byte
  assign pos_inc = (pos_r != POS_MAX) ? pos_r + POS_W'(1) : pos_r;
  assign size_ok = (pos_inc >= HDR_BYTES) &&
                   (pos_inc == HDR_BYTES + {{(POS_W-LEN_W){1'b0}}, len_nxt});

  assign result.accepted       = ok_byte && size_ok;
  assign result.sender_slot    = slot_nxt;
  assign result.message_length = len_nxt;

  assign pos_nxt = pos_inc;
  assign ok_nxt  = ok_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      ok_r   <= 1'b1;
      len_r  <= '0;
      slot_r <= '0;
    end else if (advance) begin
      if (item.frame_end) begin
        pos_r  <= '0;
        ok_r   <= 1'b1;
        len_r  <= '0;
        slot_r <= '0;
      end else begin
        pos_r  <= pos_nxt;
        ok_r   <= ok_nxt;
        len_r  <= len_nxt;
        slot_r <= slot_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/chat_request_frame_validator.sv =====
// ----------------------------------------------------------------------------
// chat_request_frame_validator
// byte-stream checker for party chat request frames: header, payload, size
// ----------------------------------------------------------------------------
//
//  channel | ports                                        | direction
//  --------+----------------------------------------------+----------
//  in      | in_valid, in_stall, in_frame_byte/frame_end   | byte in
//  out     | out_valid, out_stall, accepted/slot/length    | result out
//  cfg     | cfg_wr_en, cfg_index, cfg_wdata               | write only
//
//  one byte transaction per cycle sustained; input register, then the
//  check stage, then the result register, which sets out_valid as the
//  last byte of its frame leaves the input register
//  the check stage runs every cycle for bytes that are not the frame end;
//  only a frame end waits when the result register is still held by stall
//  rst_n is synchronous; it clears the frame state and loads the register
//  defaults (version 1, channel 1, member limit 8, max message 256)
// ----------------------------------------------------------------------------
`default_nettype none

`include "chat_request_frame_validator_defines.svh"

module chat_request_frame_validator
  import crfv_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // byte input
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_frame_byte,
  input  wire logic        in_frame_end,
  // frame result
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_accepted,
  output logic [7:0]       out_sender_slot,
  output logic [15:0]      out_message_length,
  // register writes
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  cfg_t       cfg_r;
  byte_item_t item;
  logic       item_valid;
  logic       advance;
  result_t    result;
  result_t    res_r;
  logic       out_valid_r, out_valid_nxt;

  // ---- configuration registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.version_value      <= 8'd1;
      cfg_r.party_channel_code <= 8'd1;
      cfg_r.member_limit       <= 8'd8;
      cfg_r.max_msg_len        <= 16'd256;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_VERSION:    cfg_r.version_value      <= cfg_wdata[7:0];
        CFG_CHANNEL:    cfg_r.party_channel_code <= cfg_wdata[7:0];
        CFG_MEMBER_LIM: cfg_r.member_limit       <= cfg_wdata[7:0];
        CFG_MAX_MSG:    cfg_r.max_msg_len        <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---- input register ----
  crfv_in_stage u_in_stage (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_frame_byte (in_frame_byte),
    .in_frame_end  (in_frame_end),
    .advance       (advance),
    .item_valid    (item_valid),
    .item          (item)
  );

  // a frame end needs room in the result register, other bytes always move
  assign advance = item_valid && (!item.frame_end || !out_valid_r || !out_stall);

  // ---- header and payload checks ----
  crfv_frame_chk u_frame_chk (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (item),
    .cfg     (cfg_r),
    .result  (result)
  );

  // ---- result register ----
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance && item.frame_end) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item.frame_end) begin
      res_r <= result;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_accepted       = res_r.accepted;
  assign out_sender_slot    = res_r.sender_slot;
  assign out_message_length = res_r.message_length;

  // ---- assertions ----
  // a new result only appears right after a frame end left the input register
  `CRFV_ASSERT(a_result_from_end, $rose(out_valid_r) |-> $past(advance && item.frame_end), "result without a frame end transaction")
  // back-pressure only comes from a held result blocking a frame end
  `CRFV_ASSERT(a_stall_cause, in_stall |-> (item_valid && item.frame_end && out_valid_r && out_stall), "input stalled without a blocked frame end")
  // an accepted frame always carries a nonzero slot and length
  `CRFV_ASSERT(a_accept_fields, (out_valid_r && res_r.accepted) |-> (res_r.sender_slot != 8'd0 && res_r.message_length != 16'd0), "accepted frame with zero slot or length")
  // nothing is left pending in the datapath once reset has been applied
  `CRFV_ASSERT_ALWAYS(a_reset_clear, !rst_n |=> (!out_valid_r && !item_valid), "valid left set after reset")

endmodule

`default_nettype wire
